FILE: design/ssa_pkg.sv
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared types and constants of the swap slot allocator: field widths,
// result status codes, controller states and controller/datapath bundles.
// ----------------------------------------------------------------------------
package ssa_pkg;

  // Field widths of the request, response and configuration channels
  localparam int SLOT_OUT_W = 10;
  localparam int SECTOR_W   = 13;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 11;

  // Free map word geometry
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

  // Request function codes
  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NOT_TAKEN = 2'd3
  } ssa_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_OUT
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic rd_start;
    logic advance;
    logic commit;
    logic load_out;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_release;
    logic hit;
    logic last;
  } dp_stat_t;

endpackage

FILE: design/ssa_ctrl.sv
// ----------------------------------------------------------------------------
// ssa_ctrl
// Sequencer of the swap slot allocator: takes one transaction at a time,
// walks the free map scan and hands the result to the response register.
// ----------------------------------------------------------------------------
module ssa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output ssa_pkg::ctrl_cmd_t cmd,
  input  ssa_pkg::dp_stat_t  stat
);
  import ssa_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        done;
  logic        out_free;

  // Release checks one word; allocate stops on a hit or after the last word
  assign done     = stat.is_release || stat.hit || stat.last;
  assign out_free = !rsp_valid || !rsp_stall;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_START;
      end
      S_START: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (done) state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    req_stall     = (state != S_IDLE);
    cmd.load_item = (state == S_IDLE) && req_valid;
    cmd.rd_start  = (state == S_START);
    cmd.advance   = (state == S_SCAN) && !done;
    cmd.commit    = (state == S_SCAN) && done;
    cmd.load_out  = (state == S_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the response until taken; a new load wins over the take
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

FILE: design/ssa_dpath.sv
// ----------------------------------------------------------------------------
// ssa_dpath
// Datapath of the swap slot allocator: slot count register, free map memory
// of 32-bit words with per-word valid bits, word scan with first-free search,
// result and response registers.
// ----------------------------------------------------------------------------
module ssa_dpath #(
  parameter int MAX_SLOTS        = 1024,
  parameter int SECTORS_PER_SLOT = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ssa_pkg::ctrl_cmd_t              cmd,
  output ssa_pkg::dp_stat_t               stat,
  input  logic                            func,
  input  logic [ssa_pkg::SLOT_OUT_W-1:0]  slot,
  input  logic                            cfg_we,
  input  logic [ssa_pkg::COUNT_W-1:0]     cfg_data,
  output logic [ssa_pkg::SLOT_OUT_W-1:0]  slot_out,
  output logic [ssa_pkg::SECTOR_W-1:0]    first_sector,
  output logic [ssa_pkg::STATUS_W-1:0]    status
);
  import ssa_pkg::*;

  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int NWORDS = (MAX_SLOTS + WORD_W - 1) / WORD_W;
  localparam int WIDX_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int WIDE_W = SLOT_W + COUNT_W;
  localparam int PROD_W = SLOT_W + SECTOR_W + 7;
  localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(NWORDS - 1);

  // Configuration and request registers
  logic [COUNT_W-1:0]    slot_count;
  logic                  is_release;
  logic [SLOT_OUT_W-1:0] req_slot;

  // Free map storage, 1 = free; a word never written reads as all free
  logic [WORD_W-1:0] mem [NWORDS];
  logic [NWORDS-1:0] word_valid;
  logic [WORD_W-1:0] rd_data;
  logic              rd_wvalid;
  logic [WIDX_W-1:0] chk_ptr;

  // Result registers
  logic [SLOT_OUT_W-1:0] res_slot;
  logic [SLOT_W-1:0]     res_idx;
  ssa_status_t           res_status;

  // Combinational datapath
  logic [WIDE_W-1:0] cnt_w;
  logic [WIDE_W-1:0] max_w;
  logic [WIDE_W-1:0] active_w;
  logic [WIDE_W-1:0] req_w;
  logic [WIDX_W-1:0] req_word;
  logic [BIT_W-1:0]  req_bit;
  logic [WIDE_W-1:0] chk_w;
  logic [WIDE_W-1:0] bound_word;
  logic [BIT_W-1:0]  bound_bit;
  logic [WORD_W-1:0] cur_word;
  logic [WORD_W-1:0] range_mask;
  logic [WORD_W-1:0] cand;
  logic              hit;
  logic [BIT_W-1:0]  hit_bit;
  logic              last;
  logic [WIDE_W-1:0] alloc_w;
  logic              rel_in_range;
  logic              rel_taken;
  logic              do_write;
  logic [WORD_W-1:0] wr_word;
  logic              rd_en;
  logic [WIDX_W-1:0] rd_addr;
  logic [PROD_W-1:0] prod;

  // Active slot count, clamped to the map size
  assign cnt_w    = WIDE_W'(slot_count);
  assign max_w    = WIDE_W'(MAX_SLOTS);
  assign active_w = (cnt_w > max_w) ? max_w : cnt_w;

  // Split the release slot into word and bit
  assign req_w    = WIDE_W'(req_slot);
  assign req_word = req_w[BIT_W +: WIDX_W];
  assign req_bit  = req_w[BIT_W-1:0];

  assign cur_word = rd_wvalid ? rd_data : '1;

  // Keep only the bits of the current word that lie below the active count
  assign chk_w      = WIDE_W'(chk_ptr);
  assign bound_word = active_w >> BIT_W;
  assign bound_bit  = active_w[BIT_W-1:0];

  always_comb begin
    if (chk_w < bound_word) begin
      range_mask = '1;
    end else if (chk_w == bound_word) begin
      range_mask = (WORD_W'(1) << bound_bit) - WORD_W'(1);
    end else begin
      range_mask = '0;
    end
  end

  assign cand = cur_word & range_mask;

  // Lowest free bit of the word
  always_comb begin
    hit     = |cand;
    hit_bit = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (cand[i]) hit_bit = BIT_W'(i);
    end
  end

  // Stop after the word that holds the last active slot
  assign last = (((chk_w + WIDE_W'(1)) << BIT_W) >= active_w) || (chk_ptr == LAST_WORD);

  assign alloc_w = (chk_w << BIT_W) | WIDE_W'(hit_bit);

  assign rel_in_range = (req_w < active_w);
  assign rel_taken    = !cur_word[req_bit];

  assign stat.is_release = is_release;
  assign stat.hit        = hit;
  assign stat.last       = last;

  // Map update: clear the found bit on allocate, set the bit on release
  assign do_write = cmd.commit && (is_release ? (rel_in_range && rel_taken) : hit);
  assign wr_word  = is_release ? (cur_word | (WORD_W'(1) << req_bit))
                               : (cur_word & ~(WORD_W'(1) << hit_bit));

  assign rd_en   = cmd.rd_start || cmd.advance;
  assign rd_addr = cmd.rd_start ? (is_release ? req_word : '0) : (chk_ptr + WIDX_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= COUNT_RESET;
    end else if (cfg_we) begin
      slot_count <= cfg_data;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      is_release <= (func == FUNC_RELEASE);
      req_slot   <= slot;
    end
  end

  // Free map memory
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[chk_ptr] <= wr_word;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
      rd_wvalid  <= 1'b0;
    end else begin
      if (do_write) word_valid[chk_ptr] <= 1'b1;
      if (rd_en) rd_wvalid <= word_valid[rd_addr];
    end
  end

  // Track the word under check
  always_ff @(posedge clk) begin
    if (cmd.rd_start) begin
      chk_ptr <= is_release ? req_word : '0;
    end else if (cmd.advance) begin
      chk_ptr <= chk_ptr + WIDX_W'(1);
    end
  end

  // Capture the result
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (is_release) begin
        res_slot <= req_slot;
        res_idx  <= req_w[SLOT_W-1:0];
        if (!rel_in_range) begin
          res_status <= ST_RANGE;
        end else if (!rel_taken) begin
          res_status <= ST_NOT_TAKEN;
        end else begin
          res_status <= ST_OK;
        end
      end else if (hit) begin
        res_slot   <= alloc_w[SLOT_OUT_W-1:0];
        res_idx    <= alloc_w[SLOT_W-1:0];
        res_status <= ST_OK;
      end else begin
        res_slot   <= '0;
        res_idx    <= '0;
        res_status <= ST_FULL;
      end
    end
  end

  // Response register with the sector address
  assign prod = PROD_W'(res_idx) * PROD_W'(SECTORS_PER_SLOT);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      slot_out     <= res_slot;
      first_sector <= (res_status == ST_OK) ? prod[SECTOR_W-1:0] : '0;
      status       <= res_status;
    end
  end

endmodule

FILE: design/swap_slot_allocator.sv
// ----------------------------------------------------------------------------
// swap_slot_allocator
// First-fit bitmap allocator of swap slots with allocate and release requests.
// ----------------------------------------------------------------------------
// One transaction is worked on at a time. A release reads and checks the
// one free map word that holds its slot; an allocate examines 32-bit free
// map words from word 0 up and stops at the first word with a free slot,
// at least one word and at most ceil(min(slot_count, MAX_SLOTS) / 32) words
// (32 at the default size), as the single-port free map memory delivers one
// word per cycle to the search. While an earlier response is still stalled,
// the finished transaction waits in S_OUT until the response register is
// free. The map comes out of reset all free at once through one valid bit
// per word, so no clearing pass is needed. The response sits in an output
// register, so a new request is accepted while a response still waits. The
// user must write slot_count only while no transaction is in flight; the
// block itself does not enforce it. Counts above MAX_SLOTS act as MAX_SLOTS
// and a count change leaves the map untouched.
// ----------------------------------------------------------------------------
module swap_slot_allocator #(
  parameter int MAX_SLOTS        = 1024,
  parameter int SECTORS_PER_SLOT = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic                            func,
  input  logic [ssa_pkg::SLOT_OUT_W-1:0]  slot,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic [ssa_pkg::SLOT_OUT_W-1:0]  slot_out,
  output logic [ssa_pkg::SECTOR_W-1:0]    first_sector,
  output logic [ssa_pkg::STATUS_W-1:0]    status,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ssa_pkg::COUNT_W-1:0]     cfg_data
);
  import ssa_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  ssa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  ssa_dpath #(
    .MAX_SLOTS        (MAX_SLOTS),
    .SECTORS_PER_SLOT (SECTORS_PER_SLOT)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .func         (func),
    .slot         (slot),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .slot_out     (slot_out),
    .first_sector (first_sector),
    .status       (status)
  );

endmodule

FILE: design/ssa_checker.sv
// ----------------------------------------------------------------------------
// ssa_checker
// Port-level checks of the swap slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ssa_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_stall,
  input logic                            rsp_valid,
  input logic                            rsp_stall,
  input logic [ssa_pkg::SLOT_OUT_W-1:0]  slot_out,
  input logic [ssa_pkg::SECTOR_W-1:0]    first_sector,
  input logic [ssa_pkg::STATUS_W-1:0]    status
);
  import ssa_pkg::*;

  // A stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(slot_out) &&
      $stable(first_sector) && $stable(status))
    else $error("stalled response changed");

  // One transaction at a time: acceptance stalls the request side next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted while busy");

  // A full map returns slot and sector zero
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_FULL) |-> (slot_out == '0) && (first_sector == '0))
    else $error("no-space response carries a slot");

  // Rejected releases carry no sector
  a_err_sector: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && ((status == ST_RANGE) || (status == ST_NOT_TAKEN)) |->
      (first_sector == '0))
    else $error("rejected release carries a sector");

endmodule

bind swap_slot_allocator ssa_checker u_ssa_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req_valid),
  .req_stall    (req_stall),
  .rsp_valid    (rsp_valid),
  .rsp_stall    (rsp_stall),
  .slot_out     (slot_out),
  .first_sector (first_sector),
  .status       (status)
);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench of the swap slot allocator. A slot ledger mirrors the
// free map and the slot count, predicts the response of every accepted
// request and checks responses in order. Directed requests cover the map
// edges and all status codes; random phases at several slot counts mix
// allocates, releases of taken slots and random releases, with random gaps
// on both sides, a long receiver hold-off and a final fill to a full map.
// ----------------------------------------------------------------------------
module tb_top;
  import ssa_pkg::*;

  localparam int          MAX_SLOTS        = 1024;
  localparam int          SECTORS_PER_SLOT = 8;
  localparam int unsigned CYCLE_LIMIT      = 600000;
  localparam int          HOLD_CYCLES      = 300;

  typedef struct {
    logic [SLOT_OUT_W-1:0] slot;
    logic [SECTOR_W-1:0]   sector;
    ssa_status_t           status;
  } slot_result_t;

  // Mirror of the free map with the expected responses in order
  class slot_ledger;
    bit                    free_bits[MAX_SLOTS];
    logic [COUNT_W-1:0]    slot_limit;
    slot_result_t          awaited[$];
    int unsigned           mismatches;

    function new();
      foreach (free_bits[i]) free_bits[i] = 1'b1;
      slot_limit = COUNT_RESET;
      mismatches = 0;
    endfunction

    function int unsigned active_slots();
      return (slot_limit > MAX_SLOTS) ? MAX_SLOTS : slot_limit;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function int unsigned free_total();
      int unsigned n;
      n = 0;
      for (int i = 0; i < active_slots(); i++) n += free_bits[i];
      return n;
    endfunction

    // Pick a taken slot below the active count, or any slot if none is taken
    function logic [SLOT_OUT_W-1:0] pick_taken();
      int unsigned start;
      int unsigned idx;
      start = $urandom_range(MAX_SLOTS - 1);
      for (int k = 0; k < MAX_SLOTS; k++) begin
        idx = (start + k) % MAX_SLOTS;
        if (idx < active_slots() && !free_bits[idx]) return SLOT_OUT_W'(idx);
      end
      return SLOT_OUT_W'($urandom_range(MAX_SLOTS - 1));
    endfunction

    // Apply one accepted request to the map and queue its response
    function void note_request(logic f, logic [SLOT_OUT_W-1:0] s);
      slot_result_t r;
      bit           found;
      int unsigned  n;
      n = active_slots();
      found = 1'b0;
      if (f == FUNC_ALLOC) begin
        r.slot = '0;
        r.sector = '0;
        r.status = ST_FULL;
        for (int i = 0; i < n && !found; i++) begin
          if (free_bits[i]) begin
            free_bits[i] = 1'b0;
            r.slot = SLOT_OUT_W'(i);
            r.sector = SECTOR_W'(i * SECTORS_PER_SLOT);
            r.status = ST_OK;
            found = 1'b1;
          end
        end
      end else begin
        r.slot = s;
        r.sector = '0;
        if (s >= n) begin
          r.status = ST_RANGE;
        end else if (free_bits[s]) begin
          r.status = ST_NOT_TAKEN;
        end else begin
          free_bits[s] = 1'b1;
          r.sector = SECTOR_W'(s * SECTORS_PER_SLOT);
          r.status = ST_OK;
        end
      end
      awaited.push_back(r);
    endfunction

    function void check_result(logic [SLOT_OUT_W-1:0] so, logic [SECTOR_W-1:0] sec,
                               logic [STATUS_W-1:0] st);
      slot_result_t r;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response: slot %0d sector %0d status %0d", so, sec, st);
      end else begin
        r = awaited.pop_front();
        if (so !== r.slot || sec !== r.sector || st !== r.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected slot %0d sector %0d status %0d, got %0d %0d %0d",
                     r.slot, r.sector, r.status, so, sec, st);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  logic                  func = FUNC_ALLOC;
  logic [SLOT_OUT_W-1:0] slot = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  logic [SLOT_OUT_W-1:0] slot_out;
  logic [SECTOR_W-1:0]   first_sector;
  logic [STATUS_W-1:0]   status;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [COUNT_W-1:0]    cfg_data = '0;

  logic                  calm = 1'b0;
  logic                  hold_go = 1'b0;
  logic                  hold_done = 1'b0;
  int                    hold_left = 0;
  int unsigned           cycles = 0;

  slot_ledger ledger = new();

  swap_slot_allocator #(
    .MAX_SLOTS(MAX_SLOTS),
    .SECTORS_PER_SLOT(SECTORS_PER_SLOT)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .func(func),
    .slot(slot),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .slot_out(slot_out),
    .first_sector(first_sector),
    .status(status),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Response stall: one long hold-off on request, otherwise random stalls
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else if (calm) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99) < 19);
    end
  end

  // Check every accepted response
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) ledger.check_result(slot_out, first_sector, status);
  end

  // Offer one request and hold it until accepted
  task automatic send_request(logic f, logic [SLOT_OUT_W-1:0] s);
    req_valid <= 1'b1;
    func <= f;
    slot <= s;
    do @(posedge clk); while (req_stall);
    ledger.note_request(f, s);
  endtask

  // Random idle cycles on the request side
  task automatic request_gap();
    if (!calm && $urandom_range(99) < 19) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Change the slot count once the block is idle
  task automatic write_count(logic [COUNT_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ledger.slot_limit = v;
  endtask

  task automatic random_phase(logic [COUNT_W-1:0] cnt, int items);
    int unsigned p_alloc;
    int unsigned r;
    write_count(cnt);
    p_alloc = $urandom_range(30, 80);
    for (int k = 0; k < items; k++) begin
      request_gap();
      r = $urandom_range(99);
      if (r < p_alloc)
        send_request(FUNC_ALLOC, SLOT_OUT_W'($urandom_range(MAX_SLOTS - 1)));
      else if (r < p_alloc + (100 - p_alloc) * 3 / 4)
        send_request(FUNC_RELEASE, ledger.pick_taken());
      else
        send_request(FUNC_RELEASE, SLOT_OUT_W'($urandom_range(MAX_SLOTS - 1)));
    end
  endtask

  initial begin
    logic [COUNT_W-1:0] phase_counts[9];
    int unsigned        fill;
    phase_counts = '{11'd64, 11'd5, 11'd1024, 11'd33, 11'd2, 11'd2047, 11'd32,
                     11'd100, 11'd1};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: releases of free slots, first allocations, release and reuse
    send_request(FUNC_RELEASE, 10'd0);
    send_request(FUNC_RELEASE, 10'd1023);
    send_request(FUNC_ALLOC, 10'd0);
    send_request(FUNC_ALLOC, 10'd0);
    send_request(FUNC_ALLOC, 10'd0);
    send_request(FUNC_RELEASE, 10'd1);
    send_request(FUNC_RELEASE, 10'd1);
    send_request(FUNC_ALLOC, 10'h3FF);
    // Empty slot range
    write_count(11'd0);
    send_request(FUNC_ALLOC, 10'd0);
    send_request(FUNC_RELEASE, 10'd0);
    // Count above the map size
    write_count(11'd2047);
    send_request(FUNC_ALLOC, 10'd0);
    send_request(FUNC_RELEASE, 10'd3);
    // Small count: full map and out-of-range releases
    write_count(11'd3);
    send_request(FUNC_ALLOC, 10'd0);
    send_request(FUNC_RELEASE, 10'd3);
    send_request(FUNC_RELEASE, 10'd2);
    send_request(FUNC_ALLOC, 10'd0);
    send_request(FUNC_RELEASE, 10'd1023);
    // Taken slot above the count stays taken until the count covers it
    write_count(11'd1);
    send_request(FUNC_RELEASE, 10'd0);
    send_request(FUNC_ALLOC, 10'd0);
    send_request(FUNC_ALLOC, 10'd0);
    send_request(FUNC_RELEASE, 10'd2);
    write_count(11'd1024);
    send_request(FUNC_RELEASE, 10'd2);

    // Random phases; one without idling, one with a long response hold-off
    foreach (phase_counts[p]) begin
      if (p == 2) calm <= 1'b1;
      if (p == 3) begin
        calm <= 1'b0;
        // Start the hold-off only once the block is idle, so requests pile up
        write_count(phase_counts[p]);
        hold_go <= 1'b1;
      end
      random_phase(phase_counts[p], 35);
    end

    // Fill the low slots to a full map, then free and reuse the top slot
    write_count(11'd64);
    fill = ledger.free_total();
    for (int k = 0; k <= fill; k++) begin
      request_gap();
      send_request(FUNC_ALLOC, SLOT_OUT_W'($urandom_range(MAX_SLOTS - 1)));
    end
    send_request(FUNC_RELEASE, 10'd63);
    send_request(FUNC_ALLOC, 10'd0);

    drain();
    repeat (40) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
